// ===== src/abkf_pkg.sv =====
`default_nettype none

package abkf_pkg;

    localparam int unsigned ANGLE_W = 32;
    localparam int unsigned VAR_W   = 48;
    localparam int unsigned DT_W    = 24;
    localparam int unsigned WORK_W  = 64;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [VAR_W-1:0] Q_ANGLE_RESET = 48'd4294967;
    localparam logic [VAR_W-1:0] Q_BIAS_RESET  = 48'd12884902;
    localparam logic [VAR_W-1:0] R_MEAS_RESET  = 48'd429496729600;

    localparam logic [WORK_W-1:0] PROD_LIM = 64'h4000_0000_0000_0000;
    localparam logic [VAR_W-1:0]  GAIN_LIM = 48'h7FFF_FFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef struct packed {
        logic                      cmd;
        logic signed [ANGLE_W-1:0] measured_angle;
        logic signed [ANGLE_W-1:0] measured_rate;
        logic [DT_W-1:0]           time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_estimate;
        logic signed [ANGLE_W-1:0] unbiased_rate;
    } t_out_item;

    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [WORK_W-1:0] v);
        logic signed [WORK_W-1:0] hi;
        logic signed [WORK_W-1:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi[ANGLE_W-1:0];
        end else if (v < lo) begin
            return lo[ANGLE_W-1:0];
        end
        return v[ANGLE_W-1:0];
    endfunction

    function automatic logic signed [VAR_W-1:0] sat48(input logic signed [WORK_W-1:0] v);
        logic signed [WORK_W-1:0] hi;
        logic signed [WORK_W-1:0] lo;
        hi = 64'sh0000_7FFF_FFFF_FFFF;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi[VAR_W-1:0];
        end else if (v < lo) begin
            return lo[VAR_W-1:0];
        end
        return v[VAR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/abkf_in_if.sv =====
`default_nettype none

interface abkf_in_if;
    import abkf_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/abkf_out_if.sv =====
`default_nettype none

interface abkf_out_if;
    import abkf_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/angle_bias_kalman_filter.sv =====
`default_nettype none

// Two-state angle/bias Kalman filter. An update beat predicts the angle and
// covariance from the gyro rate and time step, then corrects them with the
// measured angle; a load beat overwrites the angle only. Every beat yields
// one result beat with the angle estimate and the unbiased rate. An update
// runs ten multiplies on one shared 32x32 multiplier and two gain divisions
// on one shared radix-2 divider. The input is ready only while no item is in
// work; a finished result waits in the output register while the next input
// beat is taken, and a result that cannot enter the output register holds
// the filter until the register drains.
module angle_bias_kalman_filter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    abkf_in_if.sink                                i_in,
    abkf_out_if.source                             o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [abkf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [abkf_pkg::VAR_W-1:0]        i_cfg_data
);
    import abkf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ANG, S_T, S_P00, S_P11, S_K0, S_K1,
        S_A, S_B, S_C3, S_C2, S_C1, S_C0, S_DONE
    } t_state;

    t_state r_state;

    logic [VAR_W-1:0] r_q_angle;
    logic [VAR_W-1:0] r_q_bias;
    logic [VAR_W-1:0] r_r_meas;

    logic signed [ANGLE_W-1:0] r_angle;
    logic signed [ANGLE_W-1:0] r_bias;
    logic signed [ANGLE_W-1:0] r_rate;
    logic signed [VAR_W-1:0]   r_p00;
    logic signed [VAR_W-1:0]   r_p01;
    logic signed [VAR_W-1:0]   r_p10;
    logic signed [VAR_W-1:0]   r_p11;

    logic signed [ANGLE_W-1:0] r_meas;
    logic [DT_W-1:0]           r_dt;
    logic signed [WORK_W-1:0]  r_s;
    logic signed [WORK_W-1:0]  r_y;
    logic signed [WORK_W-1:0]  r_k0;
    logic signed [WORK_W-1:0]  r_k1;

    logic                      r_mul_go;
    logic signed [WORK_W-1:0]  r_mul_a;
    logic signed [WORK_W-1:0]  r_mul_b;
    logic                      r_mul_sh32;
    logic                      r_div_go;
    logic signed [WORK_W-1:0]  r_div_p;
    logic [WORK_W-1:0]         r_div_s;

    logic                      r_out_valid;
    t_out_item                 r_out_data;

    logic                      mul_busy;
    logic                      mul_done;
    logic signed [WORK_W-1:0]  mul_res;
    logic                      div_busy;
    logic                      div_done;
    logic signed [WORK_W-1:0]  div_res;

    logic                      in_fire;
    logic signed [ANGLE_W-1:0] new_rate;
    logic signed [WORK_W-1:0]  dt_w;
    logic signed [WORK_W-1:0]  inner;
    logic signed [WORK_W-1:0]  s_next;
    logic signed [VAR_W-1:0]   p00_pred;

    assign in_fire  = i_in.valid & i_in.ready;
    assign new_rate = sat32(WORK_W'(i_in.data.measured_rate) - WORK_W'(r_bias));
    assign dt_w     = $signed({40'd0, r_dt});
    assign inner    = mul_res - WORK_W'(r_p01) - WORK_W'(r_p10)
                      + $signed({16'd0, r_q_angle});
    assign p00_pred = sat48(WORK_W'(r_p00) + mul_res);
    assign s_next   = WORK_W'(r_p00) + $signed({16'd0, r_r_meas});

    abkf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_mul_go),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .i_sh32  (r_mul_sh32),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    abkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_p     (r_div_p),
        .i_s     (r_div_s),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q_angle   <= Q_ANGLE_RESET;
            r_q_bias    <= Q_BIAS_RESET;
            r_r_meas    <= R_MEAS_RESET;
            r_angle     <= '0;
            r_bias      <= '0;
            r_rate      <= '0;
            r_p00       <= '0;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= '0;
            r_mul_go    <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            if (o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ANGLE_NOISE: r_q_angle <= i_cfg_data;
                    CFG_BIAS_NOISE:  r_q_bias  <= i_cfg_data;
                    CFG_MEAS_NOISE:  r_r_meas  <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_meas <= i_in.data.measured_angle;
                        r_dt   <= i_in.data.time_step;
                        if (i_in.data.cmd == CMD_LOAD) begin
                            r_angle <= i_in.data.measured_angle;
                            r_state <= S_DONE;
                        end else begin
                            r_rate     <= new_rate;
                            r_mul_a    <= $signed({40'd0, i_in.data.time_step});
                            r_mul_b    <= WORK_W'(new_rate);
                            r_mul_sh32 <= 1'b0;
                            r_mul_go   <= 1'b1;
                            r_state    <= S_ANG;
                        end
                    end
                end
                S_ANG: begin
                    if (mul_done) begin
                        r_angle  <= sat32(WORK_W'(r_angle) + mul_res);
                        r_mul_a  <= dt_w;
                        r_mul_b  <= WORK_W'(r_p11);
                        r_mul_go <= 1'b1;
                        r_state  <= S_T;
                    end
                end
                S_T: begin
                    if (mul_done) begin
                        r_p01    <= sat48(WORK_W'(r_p01) - mul_res);
                        r_p10    <= sat48(WORK_W'(r_p10) - mul_res);
                        r_mul_a  <= dt_w;
                        r_mul_b  <= inner;
                        r_mul_go <= 1'b1;
                        r_y      <= WORK_W'(r_meas) - WORK_W'(r_angle);
                        r_state  <= S_P00;
                    end
                end
                S_P00: begin
                    if (mul_done) begin
                        r_p00    <= p00_pred;
                        r_mul_a  <= $signed({16'd0, r_q_bias});
                        r_mul_b  <= dt_w;
                        r_mul_go <= 1'b1;
                        r_state  <= S_P11;
                    end
                end
                S_P11: begin
                    if (mul_done) begin
                        r_p11 <= sat48(WORK_W'(r_p11) + mul_res);
                        r_s   <= s_next;
                        // A nonpositive innovation variance skips the correction.
                        if (s_next > 64'sd0) begin
                            r_div_p  <= WORK_W'(r_p00);
                            r_div_s  <= s_next;
                            r_div_go <= 1'b1;
                            r_state  <= S_K0;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_K0: begin
                    if (div_done) begin
                        r_k0     <= div_res;
                        r_div_p  <= WORK_W'(r_p10);
                        r_div_s  <= r_s;
                        r_div_go <= 1'b1;
                        r_state  <= S_K1;
                    end
                end
                S_K1: begin
                    if (div_done) begin
                        r_k1       <= div_res;
                        r_mul_a    <= r_k0;
                        r_mul_b    <= r_y;
                        r_mul_sh32 <= 1'b1;
                        r_mul_go   <= 1'b1;
                        r_state    <= S_A;
                    end
                end
                S_A: begin
                    if (mul_done) begin
                        r_angle  <= sat32(WORK_W'(r_angle) + mul_res);
                        r_mul_a  <= r_k1;
                        r_mul_b  <= r_y;
                        r_mul_go <= 1'b1;
                        r_state  <= S_B;
                    end
                end
                // Covariance entries are corrected last to first, so each
                // product still sees the predicted values it needs.
                S_B: begin
                    if (mul_done) begin
                        r_bias   <= sat32(WORK_W'(r_bias) + mul_res);
                        r_mul_a  <= r_k1;
                        r_mul_b  <= WORK_W'(r_p01);
                        r_mul_go <= 1'b1;
                        r_state  <= S_C3;
                    end
                end
                S_C3: begin
                    if (mul_done) begin
                        r_p11    <= sat48(WORK_W'(r_p11) - mul_res);
                        r_mul_a  <= r_k1;
                        r_mul_b  <= WORK_W'(r_p00);
                        r_mul_go <= 1'b1;
                        r_state  <= S_C2;
                    end
                end
                S_C2: begin
                    if (mul_done) begin
                        r_p10    <= sat48(WORK_W'(r_p10) - mul_res);
                        r_mul_a  <= r_k0;
                        r_mul_b  <= WORK_W'(r_p01);
                        r_mul_go <= 1'b1;
                        r_state  <= S_C1;
                    end
                end
                S_C1: begin
                    if (mul_done) begin
                        r_p01    <= sat48(WORK_W'(r_p01) - mul_res);
                        r_mul_a  <= r_k0;
                        r_mul_b  <= WORK_W'(r_p00);
                        r_mul_go <= 1'b1;
                        r_state  <= S_C0;
                    end
                end
                S_C0: begin
                    if (mul_done) begin
                        r_p00   <= sat48(WORK_W'(r_p00) - mul_res);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_data.angle_estimate <= r_angle;
                        r_out_data.unbiased_rate  <= r_rate;
                        r_out_valid               <= 1'b1;
                        r_state                   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    a_mul_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_go |-> (r_state != S_IDLE) && !div_busy)
        else $error("multiply started outside an update");

    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !mul_busy && !div_busy)
        else $error("input ready while an arithmetic unit is busy");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && (!r_out_valid || o_out.ready)
        |=> r_out_valid && (r_state == S_IDLE))
        else $error("result not presented after finishing an item");

    a_div_go_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> (r_state == S_K0) || (r_state == S_K1))
        else $error("divide started outside the gain steps");

endmodule

`default_nettype wire

// ===== src/abkf_mul.sv =====
`default_nettype none

module abkf_mul (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_go,
    input  wire logic signed [abkf_pkg::WORK_W-1:0]   i_a,
    input  wire logic signed [abkf_pkg::WORK_W-1:0]   i_b,
    input  wire logic                                 i_sh32,
    output logic                                      o_busy,
    output logic                                      o_done,
    output logic signed [abkf_pkg::WORK_W-1:0]        o_res
);
    import abkf_pkg::*;

    logic [WORK_W-1:0]   r_a;
    logic [WORK_W-1:0]   r_b;
    logic                r_neg;
    logic                r_sh32;
    logic [2*WORK_W-1:0] r_acc;
    logic [1:0]          r_cnt;
    logic                r_busy;
    logic                r_fin;
    logic                r_done;
    logic signed [WORK_W-1:0] r_res;

    logic [31:0]         a_half;
    logic [31:0]         b_half;
    logic [63:0]         pp;
    logic [1:0]          units;
    logic [2*WORK_W-1:0] shifted;
    logic [WORK_W-1:0]   mag;

    // One 32x32 partial product per cycle, low halves first.
    assign a_half  = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign b_half  = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign pp      = a_half * b_half;
    assign units   = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
    assign shifted = r_sh32 ? (r_acc >> 32) : (r_acc >> 24);
    assign mag     = (shifted > {64'd0, PROD_LIM}) ? PROD_LIM : shifted[WORK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_go) begin
                r_a    <= i_a[WORK_W-1] ? (-i_a) : i_a;
                r_b    <= i_b[WORK_W-1] ? (-i_b) : i_b;
                r_neg  <= i_a[WORK_W-1] ^ i_b[WORK_W-1];
                r_sh32 <= i_sh32;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + ({64'd0, pp} << {units, 5'd0});
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_res  <= r_neg ? -$signed(mag) : $signed(mag);
                r_done <= 1'b1;
            end
        end
    end

    assign o_busy = r_busy | r_fin;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== src/abkf_div.sv =====
`default_nettype none

module abkf_div (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_go,
    input  wire logic signed [abkf_pkg::WORK_W-1:0]   i_p,
    input  wire logic        [abkf_pkg::WORK_W-1:0]   i_s,
    output logic                                      o_busy,
    output logic                                      o_done,
    output logic signed [abkf_pkg::WORK_W-1:0]        o_res
);
    import abkf_pkg::*;

    localparam int unsigned NUM_W = VAR_W + 32;

    logic [NUM_W-1:0]  r_num;
    logic [WORK_W-1:0] r_den;
    logic [WORK_W-1:0] r_rem;
    logic [VAR_W-1:0]  r_q;
    logic              r_over;
    logic              r_neg;
    logic [6:0]        r_cnt;
    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    logic signed [WORK_W-1:0] r_res;

    logic [WORK_W-1:0] p_mag;
    logic [WORK_W-1:0] rem2;
    logic              qb;
    logic [VAR_W:0]    q2;
    logic [WORK_W-1:0] fin_mag;

    assign p_mag   = i_p[WORK_W-1] ? (-i_p) : i_p;
    assign rem2    = {r_rem[WORK_W-2:0], r_num[NUM_W-1]};
    assign qb      = (rem2 >= r_den);
    assign q2      = {r_q, qb};
    assign fin_mag = r_over ? {16'd0, GAIN_LIM} : {16'd0, r_q};

    // Restoring division, one quotient bit per cycle; the quotient freezes
    // once it passes the gain limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_go) begin
                r_num  <= {p_mag[VAR_W-1:0], 32'd0};
                r_den  <= i_s;
                r_rem  <= '0;
                r_q    <= '0;
                r_over <= 1'b0;
                r_neg  <= i_p[WORK_W-1];
                r_cnt  <= 7'(NUM_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_rem <= qb ? (rem2 - r_den) : rem2;
                if (!r_over) begin
                    if (q2 > {1'b0, GAIN_LIM}) begin
                        r_over <= 1'b1;
                    end else begin
                        r_q <= q2[VAR_W-1:0];
                    end
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_res  <= r_neg ? -$signed(fin_mag) : $signed(fin_mag);
                r_done <= 1'b1;
            end
        end
    end

    assign o_busy = r_busy | r_fin;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire
